// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check, disabled while the active-low reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication check, disabled while the active-low reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/xdwm_pkg.sv =====
// Package for the x-drive wheel mixer: types, angle constants, CORDIC table.
// No dependencies.
`default_nettype none
package xdwm_pkg;
    localparam int CordicSteps = 14;
    localparam int StepW = 4;

    localparam logic signed [15:0] AngPi      = 16'sd25736;
    localparam logic signed [15:0] AngHalfPi  = 16'sd12868;
    localparam logic signed [15:0] AngQtrPi   = 16'sd6434;
    localparam logic signed [15:0] AngPi12    = 16'sd2145;
    localparam logic signed [15:0] Ang5Pi12   = 16'sd10723;
    localparam logic signed [15:0] Ang7Pi12   = 16'sd15013;
    localparam logic signed [15:0] Ang11Pi12  = 16'sd23592;
    localparam logic signed [16:0] GainInvQ16 = 17'sd39797;
    localparam logic signed [19:0] GainInvQ15 = 20'sd19899;

    typedef enum logic [3:0] {
        S_IDLE, S_VEC_INIT, S_VEC, S_MAG, S_SNAP, S_ROT, S_NORM, S_DIV, S_WHEEL, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        C_NONE, C_LOAD, C_VEC_INIT, C_VEC_STEP, C_MAG, C_SNAP, C_ROT_STEP, C_NORM,
        C_DIV_STEP, C_WHEEL
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic [StepW-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic zero_vec;
        logic div_done;
    } t_status;

    function automatic logic signed [15:0] atan_tab(input logic [StepW-1:0] i);
        logic signed [15:0] v;
        unique case (i)
            4'd0:  v = 16'sd6434;
            4'd1:  v = 16'sd3798;
            4'd2:  v = 16'sd2007;
            4'd3:  v = 16'sd1019;
            4'd4:  v = 16'sd511;
            4'd5:  v = 16'sd256;
            4'd6:  v = 16'sd128;
            4'd7:  v = 16'sd64;
            4'd8:  v = 16'sd32;
            4'd9:  v = 16'sd16;
            4'd10: v = 16'sd8;
            4'd11: v = 16'sd4;
            4'd12: v = 16'sd2;
            4'd13: v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== design/xdwm_if.sv =====
// Valid/ready channel interfaces for stick samples and wheel powers.
// No dependencies.
`default_nettype none
interface xdwm_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
    logic signed [7:0] turn_axis;
    logic              flip_press;
    modport source (output valid, stick_x, stick_y, turn_axis, flip_press, input ready);
    modport sink   (input valid, stick_x, stick_y, turn_axis, flip_press, output ready);
endinterface

interface xdwm_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] left_front_power;
    logic signed [8:0] right_front_power;
    logic signed [8:0] left_back_power;
    logic signed [8:0] right_back_power;
    modport source (output valid, left_front_power, right_front_power, left_back_power,
                    right_back_power, input ready);
    modport sink   (input valid, left_front_power, right_front_power, left_back_power,
                    right_back_power, output ready);
endinterface
`default_nettype wire

// ===== design/xdwm_ctrl.sv =====
// Sequencer for the wheel mixer: steps the datapath through CORDIC, divide, output.
// Depends on xdwm_pkg.
`default_nettype none
module xdwm_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  xdwm_pkg::t_status   i_status,
    output xdwm_pkg::t_cmd      o_cmd
);
    xdwm_pkg::t_state r_state, n_state;
    logic [xdwm_pkg::StepW-1:0] r_step, n_step;
    logic last_step;

    assign last_step = (r_step == xdwm_pkg::StepW'(xdwm_pkg::CordicSteps - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xdwm_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            xdwm_pkg::S_IDLE: if (i_in_valid) n_state = xdwm_pkg::S_VEC_INIT;
            xdwm_pkg::S_VEC_INIT: begin
                n_step = '0;
                n_state = i_status.zero_vec ? xdwm_pkg::S_SNAP : xdwm_pkg::S_VEC;
            end
            xdwm_pkg::S_VEC: begin
                n_step = r_step + 1'b1;
                if (last_step) begin
                    n_step = '0;
                    n_state = xdwm_pkg::S_MAG;
                end
            end
            xdwm_pkg::S_MAG:  n_state = xdwm_pkg::S_SNAP;
            xdwm_pkg::S_SNAP: begin
                n_step = '0;
                n_state = xdwm_pkg::S_ROT;
            end
            xdwm_pkg::S_ROT: begin
                n_step = r_step + 1'b1;
                if (last_step) begin
                    n_step = '0;
                    n_state = xdwm_pkg::S_NORM;
                end
            end
            xdwm_pkg::S_NORM: n_state = xdwm_pkg::S_DIV;
            xdwm_pkg::S_DIV:  if (i_status.div_done) n_state = xdwm_pkg::S_WHEEL;
            xdwm_pkg::S_WHEEL: n_state = xdwm_pkg::S_OUT;
            xdwm_pkg::S_OUT:  if (i_out_ready) n_state = xdwm_pkg::S_IDLE;
            default: n_state = xdwm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.op    = xdwm_pkg::C_NONE;
        o_cmd.step  = r_step;
        unique case (r_state)
            xdwm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = xdwm_pkg::C_LOAD;
            end
            xdwm_pkg::S_VEC_INIT: o_cmd.op = xdwm_pkg::C_VEC_INIT;
            xdwm_pkg::S_VEC:      o_cmd.op = xdwm_pkg::C_VEC_STEP;
            xdwm_pkg::S_MAG:      o_cmd.op = xdwm_pkg::C_MAG;
            xdwm_pkg::S_SNAP:     o_cmd.op = xdwm_pkg::C_SNAP;
            xdwm_pkg::S_ROT:      o_cmd.op = xdwm_pkg::C_ROT_STEP;
            xdwm_pkg::S_NORM:     o_cmd.op = xdwm_pkg::C_NORM;
            xdwm_pkg::S_DIV:      o_cmd.op = xdwm_pkg::C_DIV_STEP;
            xdwm_pkg::S_WHEEL:    o_cmd.op = xdwm_pkg::C_WHEEL;
            xdwm_pkg::S_OUT:      o_out_valid = 1'b1;
            default:              o_cmd.op = xdwm_pkg::C_NONE;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/xdwm_dp.sv =====
// Datapath for the wheel mixer: vectoring and rotation CORDIC, ratio divider, wheel sums.
// Depends on xdwm_pkg.
`default_nettype none
module xdwm_dp (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  xdwm_pkg::t_cmd          i_cmd,
    output xdwm_pkg::t_status       o_status,
    input  wire signed [7:0]        i_stick_x,
    input  wire signed [7:0]        i_stick_y,
    input  wire signed [7:0]        i_turn_axis,
    input  wire                     i_flip_press,
    output logic signed [8:0]       o_lf,
    output logic signed [8:0]       o_rf,
    output logic signed [8:0]       o_lb,
    output logic signed [8:0]       o_rb
);
    logic              r_rev;
    logic signed [7:0] r_sx, r_sy, r_turn;
    logic signed [19:0] r_vx, r_vy;       // shared CORDIC x/y
    logic signed [16:0] r_z;              // angle accumulator
    logic               r_neg;
    logic signed [16:0] r_pw;             // magnitude, Q8 percent
    logic               r_zero;
    // divider: both quotients found bit by bit in parallel, 17 steps
    logic [35:0] r_rems, r_remc;
    logic [16:0] r_qs, r_qc;
    logic [18:0] r_den;
    logic [4:0]  r_dcnt;
    logic        r_ssgn, r_csgn;
    logic signed [8:0] r_lf, r_rf, r_lb, r_rb;

    logic signed [8:0]  x9, y9;
    logic signed [19:0] dx, dy;
    logic signed [16:0] at;
    logic signed [16:0] th, phi;
    logic signed [36:0] magprod;
    logic [19:0] as_v, ac_v, mx;
    logic [35:0] dsh;
    logic        ge_s, ge_c;
    logic signed [17:0] rs, rc;
    logic signed [36:0] ps, pc;
    logic signed [36:0] tv;

    always_comb begin
        x9 = r_rev ? -9'(r_sx) : 9'(r_sx);
        y9 = r_rev ? 9'(r_sy) : -9'(r_sy);
        dx = r_vy >>> i_cmd.step;
        dy = r_vx >>> i_cmd.step;
        at = 17'(xdwm_pkg::atan_tab(i_cmd.step));
        magprod = 37'(r_vx) * 37'(xdwm_pkg::GainInvQ16) + 37'sd32768;
        th = r_z;
        if (th > -17'(xdwm_pkg::AngPi12) && th < 17'(xdwm_pkg::AngPi12)) th = '0;
        else if (th > -17'(xdwm_pkg::Ang7Pi12) && th < -17'(xdwm_pkg::Ang5Pi12))
            th = -17'(xdwm_pkg::AngHalfPi);
        else if (th > 17'(xdwm_pkg::Ang5Pi12) && th < 17'(xdwm_pkg::Ang7Pi12))
            th = 17'(xdwm_pkg::AngHalfPi);
        else if (th > 17'(xdwm_pkg::Ang11Pi12) || th < -17'(xdwm_pkg::Ang11Pi12))
            th = 17'(xdwm_pkg::AngPi);
        phi = th - 17'(xdwm_pkg::AngQtrPi);
        as_v = r_vy[19] ? 20'(-r_vy) : 20'(r_vy);
        ac_v = r_vx[19] ? 20'(-r_vx) : 20'(r_vx);
        mx = (as_v > ac_v) ? as_v : ac_v;
        // restoring step: divisor 2*mx aligned to quotient bit 16 - count
        dsh = 36'(r_den) << (5'd16 - r_dcnt);
        ge_s = (r_rems >= dsh);
        ge_c = (r_remc >= dsh);
        if (r_den == '0) begin
            rs = '0;
            rc = '0;
        end else begin
            rs = r_ssgn ? -18'(r_qs) : 18'(r_qs);
            rc = r_csgn ? -18'(r_qc) : 18'(r_qc);
        end
        ps = 37'(r_pw) * 37'(rs);
        pc = 37'(r_pw) * 37'(rc);
        tv = 37'(r_turn) <<< 23;
    end

    function automatic logic signed [8:0] rnd(input logic signed [36:0] v);
        logic signed [36:0] t;
        t = (v + 37'sd4194304) >>> 23;
        return t[8:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev <= 1'b0;
        end else if (i_cmd.op == xdwm_pkg::C_LOAD) begin
            r_rev <= r_rev ^ i_flip_press;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            xdwm_pkg::C_LOAD: begin
                r_sx <= i_stick_x;
                r_sy <= i_stick_y;
                r_turn <= i_turn_axis;
            end
            xdwm_pkg::C_VEC_INIT: begin
                r_zero <= (x9 == 9'sd0) && (y9 == 9'sd0);
                r_neg <= 1'b0;
                r_pw <= '0;
                if (x9 < 0) begin
                    r_vx <= -(20'(x9) <<< 8);
                    r_vy <= -(20'(y9) <<< 8);
                    r_z <= (y9 >= 0) ? 17'(xdwm_pkg::AngPi) : -17'(xdwm_pkg::AngPi);
                end else begin
                    r_vx <= 20'(x9) <<< 8;
                    r_vy <= 20'(y9) <<< 8;
                    r_z <= '0;
                end
            end
            xdwm_pkg::C_VEC_STEP: begin
                if (r_vy >= 0) begin
                    r_vx <= r_vx + dx; r_vy <= r_vy - dy; r_z <= r_z + at;
                end else begin
                    r_vx <= r_vx - dx; r_vy <= r_vy + dy; r_z <= r_z - at;
                end
            end
            xdwm_pkg::C_MAG: r_pw <= 17'(magprod >>> 16);
            xdwm_pkg::C_SNAP: begin
                r_vx <= xdwm_pkg::GainInvQ15;
                r_vy <= '0;
                if (r_zero) r_z <= -17'(xdwm_pkg::AngQtrPi);
                else if (phi < -17'(xdwm_pkg::AngHalfPi)) begin
                    r_z <= phi + 17'(xdwm_pkg::AngPi); r_neg <= 1'b1;
                end else if (phi > 17'(xdwm_pkg::AngHalfPi)) begin
                    r_z <= phi - 17'(xdwm_pkg::AngPi); r_neg <= 1'b1;
                end else r_z <= phi;
            end
            xdwm_pkg::C_ROT_STEP: begin
                if (r_z >= 0) begin
                    r_vx <= r_vx - dx; r_vy <= r_vy + dy; r_z <= r_z - at;
                end else begin
                    r_vx <= r_vx + dx; r_vy <= r_vy - dy; r_z <= r_z + at;
                end
            end
            xdwm_pkg::C_NORM: begin
                // dividend |c|*2^16 + mx over 2*mx rounds half away from zero
                r_ssgn <= r_neg ^ r_vy[19];
                r_csgn <= r_neg ^ r_vx[19];
                r_den <= {mx[17:0], 1'b0};
                r_rems <= (36'(as_v) << 16) + 36'(mx);
                r_remc <= (36'(ac_v) << 16) + 36'(mx);
                r_qs <= '0;
                r_qc <= '0;
                r_dcnt <= '0;
            end
            xdwm_pkg::C_DIV_STEP: begin
                if (ge_s) r_rems <= r_rems - dsh;
                if (ge_c) r_remc <= r_remc - dsh;
                r_qs <= {r_qs[15:0], ge_s};
                r_qc <= {r_qc[15:0], ge_c};
                r_dcnt <= r_dcnt + 1'b1;
            end
            xdwm_pkg::C_WHEEL: begin
                r_lf <= rnd(ps + tv);
                r_rf <= rnd(pc - tv);
                r_lb <= rnd(pc + tv);
                r_rb <= rnd(ps - tv);
            end
            default: begin
            end
        endcase
    end

    assign o_status.zero_vec = (x9 == 9'sd0) && (y9 == 9'sd0);
    // high during the last of the 17 divide steps
    assign o_status.div_done = (r_dcnt == 5'd16);
    assign o_lf = r_lf;
    assign o_rf = r_rf;
    assign o_lb = r_lb;
    assign o_rb = r_rb;
endmodule
`default_nettype wire

// ===== design/x_drive_wheel_mixer.sv =====
// X-drive wheel mixer: one stick sample in, four rounded wheel powers out.
// The result word comes from two 14-step CORDIC passes on one shared unit,
// a 17-step bit-serial ratio divide and the setup and multiply-add steps; a
// centered stick skips the vectoring pass. One sample is in flight at a
// time; the result is held until taken, and the next sample can be taken
// once the controller is back in idle.
// Depends on xdwm_pkg, xdwm_if, xdwm_ctrl, xdwm_dp, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module x_drive_wheel_mixer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    xdwm_in_if.sink     i_in,
    xdwm_out_if.source  o_out
);
    xdwm_pkg::t_cmd    cmd;
    xdwm_pkg::t_status status;

    xdwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    xdwm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_stick_x    (i_in.stick_x),
        .i_stick_y    (i_in.stick_y),
        .i_turn_axis  (i_in.turn_axis),
        .i_flip_press (i_in.flip_press),
        .o_lf         (o_out.left_front_power),
        .o_rf         (o_out.right_front_power),
        .o_lb         (o_out.left_back_power),
        .o_rb         (o_out.right_back_power)
    );

    `ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid)
endmodule
`default_nettype wire
